// File: rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;

	localparam int KEY_W       = 32;
	localparam int CAP_W       = 5;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} lkvc_state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic             cmp_en;
		logic             upd_en;
		logic             any_hit;
		logic             is_set;
		logic             full;
		logic [KEY_W-1:0] key;
	} lkvc_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/lkvc_cell.sv
// One recency-ordered entry of the cache; shifts toward the tail on update.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_cell #(
	parameter int VALUE_WIDTH = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lkvc_pkg::lkvc_ctrl_t        ctrl,
	input  wire logic                        prev_valid,
	input  wire logic [lkvc_pkg::KEY_W-1:0]  prev_key,
	input  wire logic [VALUE_WIDTH-1:0]      prev_data,
	input  wire logic                        below_match,
	output logic                             valid_q,
	output logic [lkvc_pkg::KEY_W-1:0]       key_q,
	output logic [VALUE_WIDTH-1:0]           data_q,
	output logic                             match_out,
	output logic [VALUE_WIDTH-1:0]           hit_data
);

	logic match_q;
	logic load;

	assign match_out = match_q | below_match;
	assign hit_data  = match_q ? data_q : '0;

	// hit: cells up to the hit shift; miss set: up to first free or, when full, the last valid cell
	always_comb begin
		if (ctrl.any_hit) begin
			load = ctrl.upd_en & match_out;
		end else begin
			load = ctrl.upd_en & ctrl.is_set &
				(ctrl.full ? valid_q : (valid_q | prev_valid));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.cmp_en) begin
				match_q <= valid_q && (key_q == ctrl.key);
			end
			if (load) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q  <= prev_key;
			data_q <= prev_data;
		end
	end

endmodule
`default_nettype wire

// File: rtl/lru_key_value_cache.sv
// Top level: LRU key-value cache built as a chain of recency-ordered cells.
// A transaction passes through the compare and update states; its result is then registered.
// A new transaction is accepted only when idle or in the update cycle of the previous one.
// A result waiting in the output register stalls the chain in its update cycle.
// Reset (arst_n, asynchronous, active low): all entries invalid, capacity 16, no output.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache #(
	parameter int ENTRIES     = 16,
	parameter int VALUE_WIDTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lkvc_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [lkvc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [lkvc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              op,
	input  wire logic signed [lkvc_pkg::KEY_W-1:0] key,
	input  wire logic [VALUE_WIDTH-1:0]            value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   hit,
	output logic [VALUE_WIDTH-1:0]                 read_value
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

	lkvc_pkg::lkvc_state_t state_q, state_d;
	lkvc_pkg::lkvc_ctrl_t  ctrl;

	logic [lkvc_pkg::CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0]           used_q;
	logic                       op_s1;
	logic [lkvc_pkg::KEY_W-1:0] key_s1;
	logic [VALUE_WIDTH-1:0]     value_s1;
	logic                       out_valid_q;
	logic                       hit_q;
	logic [VALUE_WIDTH-1:0]     read_value_q;

	logic in_fire, out_free, cmp_en, upd_fire, any_hit, full;
	logic [CMP_W-1:0] cap_ext, eff_cap;
	logic [VALUE_WIDTH-1:0] hit_value, head_data;

	logic [ENTRIES-1:0]         cell_valid;
	logic [ENTRIES-1:0]         cell_match;
	logic [lkvc_pkg::KEY_W-1:0] cell_key  [ENTRIES];
	logic [VALUE_WIDTH-1:0]     cell_data [ENTRIES];
	logic [VALUE_WIDTH-1:0]     cell_hit  [ENTRIES];

	// configuration port
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == lkvc_pkg::REG_CAPACITY) begin
			prdata = lkvc_pkg::APB_DATA_W'(capacity_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == lkvc_pkg::REG_CAPACITY) begin
			capacity_q <= pwdata[lkvc_pkg::CAP_W-1:0];
		end
	end

	// effective capacity: zero means one, clamp to ENTRIES
	always_comb begin
		cap_ext = CMP_W'(capacity_q);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end
	assign full = CMP_W'(used_q) >= eff_cap;

	// controller
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmp_en   = (state_q == lkvc_pkg::ST_CMP);
		upd_fire = (state_q == lkvc_pkg::ST_UPD) && out_free;
		in_ready = (state_q == lkvc_pkg::ST_IDLE) || upd_fire;
	end
	assign in_fire = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lkvc_pkg::ST_IDLE: begin
				if (in_fire) state_d = lkvc_pkg::ST_CMP;
			end
			lkvc_pkg::ST_CMP: begin
				state_d = lkvc_pkg::ST_UPD;
			end
			lkvc_pkg::ST_UPD: begin
				if (out_free) state_d = in_fire ? lkvc_pkg::ST_CMP : lkvc_pkg::ST_IDLE;
			end
			default: state_d = lkvc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1    <= op;
			key_s1   <= key;
			value_s1 <= value;
		end
	end

	// cell chain
	assign any_hit = cell_match[0];

	always_comb begin
		ctrl.cmp_en  = cmp_en;
		ctrl.upd_en  = upd_fire;
		ctrl.any_hit = any_hit;
		ctrl.is_set  = op_s1;
		ctrl.full    = full;
		ctrl.key     = key_s1;
	end

	always_comb begin
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_value = hit_value | cell_hit[i];
		end
	end
	assign head_data = op_s1 ? value_s1 : hit_value;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic                       p_valid;
		logic [lkvc_pkg::KEY_W-1:0] p_key;
		logic [VALUE_WIDTH-1:0]     p_data;
		logic                       below;
		if (i == 0) begin : g_head
			assign p_valid = 1'b1;
			assign p_key   = key_s1;
			assign p_data  = head_data;
		end else begin : g_body
			assign p_valid = cell_valid[i-1];
			assign p_key   = cell_key[i-1];
			assign p_data  = cell_data[i-1];
		end
		if (i == ENTRIES - 1) begin : g_tail
			assign below = 1'b0;
		end else begin : g_mid
			assign below = cell_match[i+1];
		end
		lkvc_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid (p_valid),
			.prev_key   (p_key),
			.prev_data  (p_data),
			.below_match(below),
			.valid_q    (cell_valid[i]),
			.key_q      (cell_key[i]),
			.data_q     (cell_data[i]),
			.match_out  (cell_match[i]),
			.hit_data   (cell_hit[i])
		);
	end

	// fill count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd_fire && op_s1 && !any_hit && !full) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (upd_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			hit_q        <= any_hit;
			read_value_q <= (!op_s1 && any_hit) ? hit_value : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

	// assertions
	a_used_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(used_q))
		else $error("fill count disagrees with valid cells");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid + {{(ENTRIES-1){1'b0}}, 1'b1}) & cell_valid) == '0)
		else $error("valid cells are not a contiguous prefix");

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == lkvc_pkg::ST_UPD))
		else $error("result appeared without an update cycle");

	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && read_value_q != '0) |-> hit_q)
		else $error("nonzero read value without a hit");

endmodule
`default_nettype wire
